// ===== rtl/core/wsa_pkg.sv =====
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared types and constants of the windowed sensor aggregator.
// ----------------------------------------------------------------------------
package wsa_pkg;

   localparam int WINDOW_BITS = 27;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 27'd10000;
   localparam int TIME_BITS  = 32;
   localparam int KEY_BITS   = 8;
   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_FIRST,
      ST_DIV_SECOND,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic sample;
      logic tick;
      logic clear;
   } accum_ctl_type;

endpackage

// ===== rtl/core/wsa_divider.sv =====
// ----------------------------------------------------------------------------
// wsa_divider
// Shared signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module wsa_divider #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [SAMPLE_BITS+31:0] dividend,
   input  logic [31:0]                   divisor,
   output logic                          busy,
   output logic                          done,
   output logic [SAMPLE_BITS-1:0]        quotient
);
   localparam int SUM_W = SAMPLE_BITS + 32;
   localparam int CNT_W = $clog2(SAMPLE_BITS);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [31:0]            rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [31:0]            div_ff, div_in;
   logic                   neg_ff, neg_in;

   logic [SUM_W-1:0] mag;
   logic [32:0]      trial;
   logic             fits;

   assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
   assign trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         // high part is below the divisor since the mean fits a sample
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = mag[SUM_W-1:SAMPLE_BITS];
         quo_in  = mag[SAMPLE_BITS-1:0];
         div_in  = divisor;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
         quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? SAMPLE_BITS'(-quo_ff) : quo_ff;

endmodule

// ===== rtl/core/wsa_accum.sv =====
// ----------------------------------------------------------------------------
// wsa_accum
// Window state: tick count, time stamps, keys, ok flag, count, and the
// sum, minimum and maximum of both channels.
// ----------------------------------------------------------------------------
module wsa_accum #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  wsa_pkg::accum_ctl_type        ctl,
   input  logic [31:0]                   sample_time_ms,
   input  logic [7:0]                    key_first,
   input  logic [7:0]                    key_second,
   input  logic signed [SAMPLE_BITS-1:0] value_first,
   input  logic signed [SAMPLE_BITS-1:0] value_second,
   input  logic                          sample_ok,
   output logic [31:0]                   elapsed,
   output logic [31:0]                   count,
   output logic [31:0]                   first_time,
   output logic [31:0]                   last_time,
   output logic [7:0]                    held_first,
   output logic [7:0]                    held_second,
   output logic                          ok_and,
   output logic signed [SAMPLE_BITS+31:0] sum_first,
   output logic signed [SAMPLE_BITS+31:0] sum_second,
   output logic signed [SAMPLE_BITS-1:0] min_first,
   output logic signed [SAMPLE_BITS-1:0] max_first,
   output logic signed [SAMPLE_BITS-1:0] min_second,
   output logic signed [SAMPLE_BITS-1:0] max_second
);
   localparam int SUM_W = SAMPLE_BITS + 32;
   localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [31:0]              elapsed_ff, count_ff, first_ff, last_ff;
   logic [7:0]               key0_ff, key1_ff;
   logic                     ok_ff;
   logic signed [SUM_W-1:0]  sum0_ff, sum1_ff;
   logic signed [SAMPLE_BITS-1:0] min0_ff, max0_ff, min1_ff, max1_ff;

   logic take, empty, ch1_en;

   assign empty  = count_ff == '0;
   assign take   = ctl.sample && (count_ff != wsa_pkg::COUNT_FULL);
   // channel 1 is decided by the second key of the first sample
   assign ch1_en = empty ? (key_second != '0) : (key1_ff != '0);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         elapsed_ff <= '0;
         count_ff   <= '0;
         first_ff   <= '0;
         last_ff    <= '0;
         key0_ff    <= '0;
         key1_ff    <= '0;
         ok_ff      <= 1'b1;
         sum0_ff    <= '0;
         sum1_ff    <= '0;
         min0_ff    <= MOST_POS;
         min1_ff    <= MOST_POS;
         max0_ff    <= MOST_NEG;
         max1_ff    <= MOST_NEG;
      end else begin
         if (ctl.tick) begin
            elapsed_ff <= elapsed_ff + 1'b1;
         end
         if (take) begin
            if (empty) begin
               first_ff <= sample_time_ms;
               key0_ff  <= key_first;
               key1_ff  <= key_second;
            end
            last_ff  <= sample_time_ms;
            count_ff <= count_ff + 1'b1;
            ok_ff    <= ok_ff & sample_ok;
            sum0_ff  <= sum0_ff + SUM_W'(value_first);
            if (value_first < min0_ff) begin
               min0_ff <= value_first;
            end
            if (value_first > max0_ff) begin
               max0_ff <= value_first;
            end
            if (ch1_en) begin
               sum1_ff <= sum1_ff + SUM_W'(value_second);
               if (value_second < min1_ff) begin
                  min1_ff <= value_second;
               end
               if (value_second > max1_ff) begin
                  max1_ff <= value_second;
               end
            end
         end
      end
   end

   assign elapsed     = elapsed_ff;
   assign count       = count_ff;
   assign first_time  = first_ff;
   assign last_time   = last_ff;
   assign held_first  = key0_ff;
   assign held_second = key1_ff;
   assign ok_and      = ok_ff;
   assign sum_first   = sum0_ff;
   assign sum_second  = sum1_ff;
   assign min_first   = min0_ff;
   assign max_first   = max0_ff;
   assign min_second  = min1_ff;
   assign max_second  = max1_ff;

endmodule

// ===== rtl/core/windowed_sensor_aggregator.sv =====
// ----------------------------------------------------------------------------
// windowed_sensor_aggregator
// Windowed count, time span, keys, ok flag, mean, minimum and maximum of two sensor
// channels, closed by millisecond ticks or by a flush.
// ----------------------------------------------------------------------------
// A sample, a tick that does not close the window and a close of an empty
// window are handled in idle, which the block does not leave. Closing a
// window that holds samples runs one shared restoring divider twice,
// channel 0 then channel 1, one quotient bit per cycle. The summary is
// loaded into the output register in ST_LOAD, and the block goes back to
// idle for the next request transfer once the previous summary has left
// that register or is being taken. The summary sits in an output register,
// so new transfers are taken while it waits.
module windowed_sensor_aggregator #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // sample_time_ms, key_first, key_second, value_first, value_second,
   // sample_ok, zero fill
   input  logic [((49+2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // op
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // start_ms, end_ms, out_key_first, out_key_second, sample_count, all_ok,
   // avg_first, min_first, max_first, avg_second, min_second, max_second,
   // zero fill
   output logic [((113+6*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic                 csr_we,
   input  logic [26:0]          csr_wdata
);
   localparam int SB    = SAMPLE_BITS;
   localparam int RSP_W = ((113 + 6*SB + 7) / 8) * 8;
   localparam int PAY_W = 113 + 6*SB;

   wsa_pkg::state_type state_ff, state_in;
   logic [wsa_pkg::WINDOW_BITS-1:0] window_ff;
   logic                rsp_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff;
   logic [SB-1:0]       avg0_ff;

   wsa_pkg::accum_ctl_type ctl;
   wsa_pkg::op_type op;

   logic [31:0] elapsed, count, first_time, last_time;
   logic [7:0]  held_first, held_second;
   logic        ok_and;
   logic signed [SB+31:0] sum_first, sum_second;
   logic signed [SB-1:0]  min_first, max_first, min_second, max_second;

   logic        accept, tick_close, close, out_free, load;
   logic        div_start, div_busy, div_done;
   logic [SB-1:0] quotient;
   logic        ch1;
   logic [PAY_W-1:0] payload;

   assign op         = wsa_pkg::op_type'(req_tuser);
   // ready is high exactly in idle
   assign accept     = req_tvalid && (state_ff == wsa_pkg::ST_IDLE);
   assign tick_close = 32'(elapsed + 1'b1) >= {5'd0, window_ff};
   assign close      = accept && ((op == wsa_pkg::OP_TICK && tick_close) ||
                                  op == wsa_pkg::OP_FLUSH);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   wsa_accum #(.SAMPLE_BITS(SB)) u_accum (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sample_time_ms (req_tdata[31:0]),
      .key_first      (req_tdata[39:32]),
      .key_second     (req_tdata[47:40]),
      .value_first    (req_tdata[48+SB-1:48]),
      .value_second   (req_tdata[48+2*SB-1:48+SB]),
      .sample_ok      (req_tdata[48+2*SB]),
      .elapsed        (elapsed),
      .count          (count),
      .first_time     (first_time),
      .last_time      (last_time),
      .held_first     (held_first),
      .held_second    (held_second),
      .ok_and         (ok_and),
      .sum_first      (sum_first),
      .sum_second     (sum_second),
      .min_first      (min_first),
      .max_first      (max_first),
      .min_second     (min_second),
      .max_second     (max_second)
   );

   wsa_divider #(.SAMPLE_BITS(SB)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == wsa_pkg::ST_IDLE) ? sum_first : sum_second),
      .divisor  (count),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wsa_pkg::ST_IDLE: begin
            if (close && count != '0) begin
               state_in = wsa_pkg::ST_DIV_FIRST;
            end
         end
         wsa_pkg::ST_DIV_FIRST: begin
            if (div_done) begin
               state_in = wsa_pkg::ST_DIV_SECOND;
            end
         end
         wsa_pkg::ST_DIV_SECOND: begin
            if (div_done) begin
               state_in = wsa_pkg::ST_LOAD;
            end
         end
         wsa_pkg::ST_LOAD: begin
            if (out_free) begin
               state_in = wsa_pkg::ST_IDLE;
            end
         end
         default: state_in = wsa_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      load       = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         wsa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = close && count != '0;
            ctl.sample = accept && op == wsa_pkg::OP_SAMPLE;
            ctl.tick   = accept && op == wsa_pkg::OP_TICK && !tick_close;
            ctl.clear  = close && count == '0;
         end
         wsa_pkg::ST_DIV_FIRST: begin
            div_start = div_done;
         end
         wsa_pkg::ST_DIV_SECOND: begin
         end
         wsa_pkg::ST_LOAD: begin
            load      = out_free;
            ctl.clear = out_free;
         end
         default: begin
         end
      endcase
   end

   assign ch1 = held_second != '0;
   assign payload = {
      ch1 ? max_second : SB'(0),
      ch1 ? min_second : SB'(0),
      ch1 ? quotient   : SB'(0),
      max_first,
      min_first,
      avg0_ff,
      ok_and,
      count,
      held_second,
      held_first,
      last_time,
      first_time
   };

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsa_pkg::ST_IDLE;
         window_ff    <= wsa_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == wsa_pkg::ST_DIV_FIRST && div_done) begin
         avg0_ff <= quotient;
      end
      if (load) begin
         rsp_data_ff <= RSP_W'(payload);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_idle_unit: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_ready_unit_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_busy)
      else $error("input taken during division");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid && count == '0 && state_ff == wsa_pkg::ST_IDLE)
      else $error("summary load did not restart the window");

   a_close_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == wsa_pkg::ST_LOAD |-> count != '0)
      else $error("summary of an empty window");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed sensor aggregator. A scoreboard class
// keeps its own copy of the window state and the window length, predicts a
// summary for every close of a window that held samples, and compares each
// summary transfer field by field. Stimulus is a short directed run through
// the corner cases, then random phases at several window lengths with random
// gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb;

   localparam int SAMPLE_BITS = 16;
   localparam int REQ_W = ((49 + 2*SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((113 + 6*SAMPLE_BITS + 7) / 8) * 8;
   localparam int SETTLE = 2*SAMPLE_BITS + 25;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 178;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [31:0] start_ms;
      logic [31:0] end_ms;
      logic [7:0]  key_first;
      logic [7:0]  key_second;
      logic [31:0] sample_count;
      logic        all_ok;
      logic [15:0] avg_first;
      logic [15:0] min_first;
      logic [15:0] max_first;
      logic [15:0] avg_second;
      logic [15:0] min_second;
      logic [15:0] max_second;
   } summary_type;

   class summary_board;
      summary_type due[$];
      int unsigned faults;
      logic [wsa_pkg::WINDOW_BITS-1:0] window_len;
      int unsigned elapsed;
      logic [31:0] count;
      logic [31:0] first_time;
      logic [31:0] last_time;
      logic [7:0] key0;
      logic [7:0] key1;
      logic ok_and;
      longint sums[2];
      logic signed [15:0] lo[2];
      logic signed [15:0] hi[2];

      function new();
         faults = 0;
         window_len = wsa_pkg::WINDOW_RESET;
         clear_window();
      endfunction

      function void clear_window();
         elapsed = 0;
         count = 0;
         first_time = 0;
         last_time = 0;
         key0 = 0;
         key1 = 0;
         ok_and = 1'b1;
         for (int c = 0; c < 2; c++) begin
            sums[c] = 0;
            lo[c] = 16'sh7FFF;
            hi[c] = -16'sh8000;
         end
      endfunction

      function void set_window(logic [wsa_pkg::WINDOW_BITS-1:0] v);
         window_len = v;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void close_window();
         summary_type s;
         longint cnt;
         longint q;
         if (count != 0) begin
            cnt = count;
            s.start_ms = first_time;
            s.end_ms = last_time;
            s.key_first = key0;
            s.key_second = key1;
            s.sample_count = count;
            s.all_ok = ok_and;
            q = sums[0] / cnt;
            s.avg_first = q[15:0];
            s.min_first = lo[0];
            s.max_first = hi[0];
            if (key1 != 0) begin
               q = sums[1] / cnt;
               s.avg_second = q[15:0];
               s.min_second = lo[1];
               s.max_second = hi[1];
            end else begin
               s.avg_second = 0;
               s.min_second = 0;
               s.max_second = 0;
            end
            due.push_back(s);
         end
         clear_window();
      endfunction

      // called at the edge where a request transfer completes
      function void take_item(logic [1:0] op, logic [REQ_W-1:0] d);
         logic signed [15:0] v[2];
         v[0] = d[63:48];
         v[1] = d[79:64];
         case (op)
            wsa_pkg::OP_SAMPLE: begin
               if (count != wsa_pkg::COUNT_FULL) begin
                  if (count == 0) begin
                     key0 = d[39:32];
                     key1 = d[47:40];
                     first_time = d[31:0];
                  end
                  last_time = d[31:0];
                  // channel 1 is gated by the key held from the first sample
                  for (int c = 0; c < 2; c++) begin
                     if (c == 0 || key1 != 0) begin
                        sums[c] += v[c];
                        if (v[c] < lo[c]) lo[c] = v[c];
                        if (v[c] > hi[c]) hi[c] = v[c];
                     end
                  end
                  ok_and = ok_and & d[80];
                  count++;
               end
            end
            wsa_pkg::OP_TICK: begin
               elapsed++;
               if (elapsed >= window_len) close_window();
            end
            wsa_pkg::OP_FLUSH: close_window();
            default: ;
         endcase
      endfunction

      function void field(string nm, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            faults++;
            if (faults <= 10)
               $display("tb: mismatch %s expected %h actual %h", nm, want, got);
         end
      endfunction

      function void check_summary(logic [RSP_W-1:0] d);
         summary_type w;
         if (due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("tb: summary transfer with none expected, data %h", d);
            return;
         end
         w = due.pop_front();
         field("start_ms", w.start_ms, d[31:0]);
         field("end_ms", w.end_ms, d[63:32]);
         field("key_first", w.key_first, d[71:64]);
         field("key_second", w.key_second, d[79:72]);
         field("sample_count", w.sample_count, d[111:80]);
         field("all_ok", w.all_ok, d[112]);
         field("avg_first", w.avg_first, d[128:113]);
         field("min_first", w.min_first, d[144:129]);
         field("max_first", w.max_first, d[160:145]);
         field("avg_second", w.avg_second, d[176:161]);
         field("min_second", w.min_second, d[192:177]);
         field("max_second", w.max_second, d[208:193]);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // sample_time_ms, key_first, key_second, value_first, value_second,
   // sample_ok, zero fill
   logic [REQ_W-1:0] req_tdata = '0;
   // op
   logic [1:0] req_tuser = wsa_pkg::OP_SAMPLE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // start_ms, end_ms, out_key_first, out_key_second, sample_count, all_ok,
   // avg_first, min_first, max_first, avg_second, min_second, max_second,
   // zero fill
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [wsa_pkg::WINDOW_BITS-1:0] csr_wdata = '0;

   summary_board board = new();
   bit no_stall = 1'b0;
   int unsigned cycles = 0;

   windowed_sensor_aggregator #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: done, errors");
      $finish;
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_stall || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(12, 48);
   endfunction

   function automatic logic [15:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7FFF;
      if (r < 25) return 16'h0000;
      if (r < 30) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [REQ_W-1:0] pack_sample(logic [31:0] t, logic [7:0] k0,
         logic [7:0] k1, logic [15:0] v0, logic [15:0] v1, logic ok);
      return {{(REQ_W-81){1'b0}}, ok, v1, v0, k1, k0, t};
   endfunction

   function automatic logic [REQ_W-1:0] random_sample();
      logic [7:0] k1;
      k1 = ($urandom_range(0, 99) < 35) ? 8'd0 : 8'($urandom);
      return pack_sample($urandom, 8'($urandom), k1, pick_value(), pick_value(),
                         $urandom_range(0, 99) < 88);
   endfunction

   // payload of ticks, flushes and the unused op: ignored by the block
   function automatic logic [REQ_W-1:0] random_payload();
      return pack_sample($urandom, 8'($urandom), 8'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom));
   endfunction

   task automatic send_item(logic [1:0] op, logic [REQ_W-1:0] d);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      board.take_item(op, d);
   endtask

   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      // a close of an empty window or a last sample may still be in flight
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_window(logic [wsa_pkg::WINDOW_BITS-1:0] v);
      settle_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_window(v);
   endtask

   initial begin : rsp_side
      bit rdy;
      int unsigned hold;
      int unsigned g;
      rdy = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) board.check_summary(rsp_tdata);
         if (no_stall) begin
            rdy = 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else if (rdy) begin
            g = idle_gap();
            if (g > 0) begin
               rdy = 1'b0;
               hold = g - 1;
            end else begin
               hold = $urandom_range(0, 7);
            end
         end else begin
            rdy = 1'b1;
            hold = $urandom_range(0, 10);
         end
         rsp_tready <= rdy;
      end
   end

   initial begin : stimulus
      int p;
      int n;
      int unsigned r;
      int unsigned flush_cut;
      logic [wsa_pkg::WINDOW_BITS-1:0] w;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window length: flush of an empty window, unused op, extremes
      send_item(wsa_pkg::OP_FLUSH, random_payload());
      send_item(OP_UNUSED, random_payload());
      send_item(wsa_pkg::OP_SAMPLE, pack_sample(32'h0, 8'hFF, 8'h00, 16'h8000,
                                                16'h7FFF, 1'b1));
      // second key given only after the first sample: channel 1 stays off
      send_item(wsa_pkg::OP_SAMPLE, pack_sample(32'hFFFF_FFFF, 8'h00, 8'hFF, 16'h7FFF,
                                                16'h8000, 1'b0));
      send_item(wsa_pkg::OP_FLUSH, random_payload());
      send_item(wsa_pkg::OP_SAMPLE, pack_sample(32'h1234_5678, 8'h3C, 8'h5A, 16'hFFFF,
                                                16'hFFFD, 1'b1));
      send_item(wsa_pkg::OP_SAMPLE, pack_sample(32'h1234_5679, 8'hC3, 8'h00, 16'h0002,
                                                16'h7FFF, 1'b1));
      // negative sum checks truncation toward zero
      send_item(wsa_pkg::OP_SAMPLE, pack_sample(32'h1234_567A, 8'h11, 8'h22, 16'hFFFC,
                                                16'h8000, 1'b1));
      send_item(wsa_pkg::OP_TICK, random_payload());
      send_item(wsa_pkg::OP_FLUSH, random_payload());

      write_window(27'd1);
      send_item(wsa_pkg::OP_SAMPLE, random_sample());
      send_item(wsa_pkg::OP_TICK, random_payload());
      send_item(wsa_pkg::OP_TICK, random_payload());

      // zero length: every tick closes
      write_window(27'd0);
      send_item(wsa_pkg::OP_TICK, random_payload());
      send_item(wsa_pkg::OP_SAMPLE, random_sample());
      send_item(wsa_pkg::OP_TICK, random_payload());

      // shrink the length to the ticks already counted in an open window
      write_window(27'd5);
      send_item(wsa_pkg::OP_SAMPLE, random_sample());
      send_item(wsa_pkg::OP_TICK, random_payload());
      send_item(wsa_pkg::OP_TICK, random_payload());
      write_window(27'd2);
      send_item(wsa_pkg::OP_TICK, random_payload());

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: w = 27'd0;
            1: w = 27'd1;
            2: w = 27'($urandom_range(2, 6));
            3: w = 27'h7FF_FFFF;
            4: w = 27'($urandom_range(1, 12));
            5: w = 27'd86400000;
            6: w = 27'd2;
            7: w = 27'($urandom_range(1, 40));
            8: w = wsa_pkg::WINDOW_RESET;
            default: w = 27'($urandom_range(1, 8));
         endcase
         write_window(w);
         no_stall = (p == 4);
         flush_cut = (w > 64) ? 66 : 61;
         n = 0;
         while (n < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_item(OP_UNUSED, random_payload());
            end else begin
               n++;
               if (r < 58)
                  send_item(wsa_pkg::OP_SAMPLE, random_sample());
               else if (r < flush_cut)
                  send_item(wsa_pkg::OP_FLUSH, random_payload());
               else
                  send_item(wsa_pkg::OP_TICK, random_payload());
            end
         end
      end
      no_stall = 1'b0;

      settle_idle();
      if (board.faults == 0 && board.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
